>>> hdl/wsp_pkg.sv
package wsp_pkg;

  localparam int MAX_TOKENS = 16;
  localparam int IDX_W = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
  localparam int CNT_W = $clog2(MAX_TOKENS + 1);
  localparam int POS_N = MAX_TOKENS + 1;

  localparam logic [7:0] CHAR_STAR = 8'h2a;
  localparam logic [7:0] CHAR_DOT  = 8'h2e;
  localparam logic [7:0] CHAR_A    = 8'h61;
  localparam logic [7:0] CHAR_Z    = 8'h7a;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_SUBJECT = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef struct packed {
    logic       step;
    logic       wr;
    logic       set_star;
    logic       use_tok;
    logic [7:0] sym;
  } cell_cmd_t;

endpackage

>>> hdl/wsp_in_if.sv
interface wsp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] symbol;

  modport source (output valid, output command, output symbol, input ready);
  modport sink (input valid, input command, input symbol, output ready);
endinterface

>>> hdl/wsp_out_if.sv
interface wsp_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic status;

  modport source (output valid, output matched, output status, input ready);
  modport sink (input valid, input matched, input status, output ready);
endinterface

>>> hdl/wsp_cell.sv
module wsp_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               rst_act,
  input  logic               advance,
  input  wsp_pkg::cell_cmd_t cmd,
  input  logic               hop_in,
  input  logic               close_in,
  output logic               hop_out,
  output logic               close_out,
  output logic               act_next,
  output logic               star
);

  logic [7:0] chr;
  logic       act;
  logic       star_next;
  logic       hit;
  logic       self_loop;
  logic       raw;

  always_comb begin
    star_next = cmd.wr ? 1'b0 : (cmd.set_star ? 1'b1 : star);
    hit       = (chr == wsp_pkg::CHAR_DOT) || (chr == cmd.sym);
    self_loop = cmd.step & act & hit & star & cmd.use_tok;
    hop_out   = cmd.step & act & hit & ~star & cmd.use_tok;
    raw       = self_loop | hop_in;
    act_next  = raw | close_in;
    close_out = act_next & star_next & cmd.use_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act <= rst_act;
    end else if (advance) begin
      act <= act_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      star <= star_next;
      if (cmd.wr) begin
        chr <= cmd.sym;
      end
    end
  end

endmodule

>>> hdl/wildcard_star_pattern_matcher_top.sv
// Whole-string pattern matcher: lowercase letters, '.' for any byte and '*' for
// zero or more of the preceding element, run as a row of NFA cells.
// Input channel in: command and symbol. Command clear empties the pattern,
// append adds one pattern character, subject feeds one subject byte and
// restart starts a new subject; clear and append restart the subject too.
// A bad '*', a foreign pattern character or more than 16 elements mark the
// pattern invalid until the next clear; an invalid pattern never matches.
// Output channel out: one transfer per input transfer, carrying matched (the
// subject so far fully matches) and status (1 when the pattern is invalid).
// Output valid rises in the cycle after the input transfer; one item is taken
// every cycle while the receiver keeps up: each cell compares its element in
// parallel; the epsilon closure ripples along the 16 cells in the same cycle.
// The output register holds its result while the receiver stalls; a new item
// is taken in the cycle the held result is transferred, so a stalled receiver
// stalls the input.
// Reset empties the pattern, clears the invalid flag and leaves only the
// start position active; no clearing pass is needed.
module wildcard_star_pattern_matcher_top (
  input  logic       clk,
  input  logic       rst,
  wsp_in_if.sink     in,
  wsp_out_if.source  out
);

  localparam int N = wsp_pkg::MAX_TOKENS;

  logic [wsp_pkg::CNT_W-1:0] count;
  logic [wsp_pkg::CNT_W-1:0] count_next;
  logic                      invalid;
  logic                      invalid_next;
  logic                      act_end_next;
  logic                      out_valid;
  logic                      matched_q;
  logic                      status_q;

  logic                      accept;
  wsp_pkg::cmd_t             cmd;
  logic                      step;
  logic                      is_star;
  logic                      is_tok;
  logic                      app_tok;
  logic                      app_star;
  logic                      full;
  logic [wsp_pkg::IDX_W-1:0] wr_idx;
  logic [wsp_pkg::IDX_W-1:0] last_idx;
  logic                      last_star;

  logic [N-1:0]              star_vec;
  logic [N-1:0]              hop;
  logic [N-1:0]              close_o;
  logic [N-1:0]              act_nx;
  logic [wsp_pkg::POS_N-1:0] act_all_next;
  logic                      matched_next;
  wsp_pkg::cell_cmd_t        cell_cmd [N];

  assign accept   = in.valid & in.ready;
  assign in.ready = ~out_valid | out.ready;
  assign cmd      = wsp_pkg::cmd_t'(in.command);
  assign step     = (cmd == wsp_pkg::CMD_SUBJECT);

  always_comb begin
    is_star   = (in.symbol == wsp_pkg::CHAR_STAR);
    is_tok    = ((in.symbol >= wsp_pkg::CHAR_A) && (in.symbol <= wsp_pkg::CHAR_Z)) ||
                (in.symbol == wsp_pkg::CHAR_DOT);
    full      = (count == wsp_pkg::CNT_W'(N));
    wr_idx    = count[wsp_pkg::IDX_W-1:0];
    last_idx  = wsp_pkg::IDX_W'(count - wsp_pkg::CNT_W'(1));
    last_star = star_vec[last_idx];
    app_tok   = 1'b0;
    app_star  = 1'b0;
    count_next   = count;
    invalid_next = invalid;
    unique case (cmd)
      wsp_pkg::CMD_CLEAR: begin
        count_next   = '0;
        invalid_next = 1'b0;
      end
      wsp_pkg::CMD_APPEND: begin
        if (!invalid) begin
          if (is_star) begin
            if ((count == '0) || last_star) begin
              invalid_next = 1'b1;
            end else begin
              app_star = 1'b1;
            end
          end else if (is_tok) begin
            if (full) begin
              invalid_next = 1'b1;
            end else begin
              app_tok    = 1'b1;
              count_next = count + wsp_pkg::CNT_W'(1);
            end
          end else begin
            invalid_next = 1'b1;
          end
        end
      end
      wsp_pkg::CMD_SUBJECT: begin
      end
      wsp_pkg::CMD_RESTART: begin
      end
      default: begin
      end
    endcase
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    always_comb begin
      cell_cmd[i].step     = step;
      cell_cmd[i].wr       = app_tok & (wr_idx == wsp_pkg::IDX_W'(i));
      cell_cmd[i].set_star = app_star & (last_idx == wsp_pkg::IDX_W'(i));
      cell_cmd[i].use_tok  = (count_next > wsp_pkg::CNT_W'(i));
      cell_cmd[i].sym      = in.symbol;
    end

    wsp_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .rst_act  ((i == 0) ? 1'b1 : 1'b0),
      .advance  (accept),
      .cmd      (cell_cmd[i]),
      .hop_in   ((i == 0) ? ~step : hop[(i == 0) ? 0 : i - 1]),
      .close_in ((i == 0) ? 1'b0 : close_o[(i == 0) ? 0 : i - 1]),
      .hop_out  (hop[i]),
      .close_out(close_o[i]),
      .act_next (act_nx[i]),
      .star     (star_vec[i])
    );
  end

  assign act_end_next = hop[N-1] | close_o[N-1];
  assign act_all_next = {act_end_next, act_nx};
  assign matched_next = ~invalid_next & act_all_next[count_next];

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      invalid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        invalid   <= invalid_next;
        out_valid <= 1'b1;
      end else if (out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      matched_q <= matched_next;
      status_q  <= invalid_next;
    end
  end

  assign out.valid   = out_valid;
  assign out.matched = matched_q;
  assign out.status  = status_q;

endmodule

>>> verif/wildcard_star_pattern_matcher_top_tb.sv
module wildcard_star_pattern_matcher_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 200000;
  localparam int PHASE_ITEMS = 112;

  typedef struct packed {
    wsp_pkg::cmd_t command;
    logic [7:0]    symbol;
  } item_t;

  typedef struct packed {
    logic matched;
    logic status;
  } verdict_t;

  logic clk;
  logic rst;

  wsp_in_if in_if ();
  wsp_out_if out_if ();

  wildcard_star_pattern_matcher_top uut (
    .clk (clk),
    .rst (rst),
    .in  (in_if),
    .out (out_if)
  );

  item_t    pend_q[$];
  verdict_t verdict_q[$];
  int       n_err = 0;
  int       n_fed;
  int       cyc = 0;
  int       send_idle;
  int       recv_stall;

  // predictor state
  logic [7:0]                tok_ch[wsp_pkg::MAX_TOKENS];
  logic                      tok_st[wsp_pkg::MAX_TOKENS];
  int                        tok_cnt = 0;
  logic [wsp_pkg::POS_N-1:0] act = wsp_pkg::POS_N'(1);
  logic                      bad = 1'b0;

  // pattern last built by the generator, used to shape matching subjects
  logic [7:0] pat_ch[wsp_pkg::MAX_TOKENS];
  logic       pat_st[wsp_pkg::MAX_TOKENS];
  int         pat_n;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [wsp_pkg::POS_N-1:0] close_eps(logic [wsp_pkg::POS_N-1:0] a);
    logic [wsp_pkg::POS_N-1:0] r;
    r = a;
    for (int i = 0; i < tok_cnt; i++) begin
      if (r[i] && tok_st[i]) r[i+1] = 1'b1;
    end
    return r;
  endfunction

  function automatic verdict_t step_matcher(wsp_pkg::cmd_t c, logic [7:0] s);
    verdict_t                  v;
    logic [wsp_pkg::POS_N-1:0] nxt;
    case (c)
      wsp_pkg::CMD_CLEAR: begin
        tok_cnt = 0;
        bad = 1'b0;
        act = close_eps(wsp_pkg::POS_N'(1));
      end
      wsp_pkg::CMD_APPEND: begin
        if (!bad) begin
          if (s == wsp_pkg::CHAR_STAR) begin
            if (tok_cnt == 0 || tok_st[tok_cnt-1]) bad = 1'b1;
            else tok_st[tok_cnt-1] = 1'b1;
          end else if ((s >= wsp_pkg::CHAR_A && s <= wsp_pkg::CHAR_Z) ||
                       s == wsp_pkg::CHAR_DOT) begin
            if (tok_cnt >= wsp_pkg::MAX_TOKENS) begin
              bad = 1'b1;
            end else begin
              tok_ch[tok_cnt] = s;
              tok_st[tok_cnt] = 1'b0;
              tok_cnt++;
            end
          end else begin
            bad = 1'b1;
          end
        end
        act = close_eps(wsp_pkg::POS_N'(1));
      end
      wsp_pkg::CMD_SUBJECT: begin
        nxt = '0;
        for (int i = 0; i < tok_cnt; i++) begin
          if (act[i] && (tok_ch[i] == wsp_pkg::CHAR_DOT || tok_ch[i] == s)) begin
            if (tok_st[i]) nxt[i] = 1'b1;
            else nxt[i+1] = 1'b1;
          end
        end
        act = close_eps(nxt);
      end
      default: begin
        act = close_eps(wsp_pkg::POS_N'(1));
      end
    endcase
    v.matched = !bad && act[tok_cnt];
    v.status  = bad;
    return v;
  endfunction

  task automatic push_item(wsp_pkg::cmd_t c, logic [7:0] s);
    item_t it;
    it.command = c;
    it.symbol  = s;
    pend_q.push_back(it);
    n_fed++;
  endtask

  task automatic gen_pattern();
    int         n;
    logic [7:0] ch;
    logic       wide;
    push_item(wsp_pkg::CMD_CLEAR, 8'($urandom_range(255)));
    pat_n = 0;
    n = ($urandom_range(99) < 12) ? $urandom_range(15, 17) : $urandom_range(0, 6);
    wide = ($urandom_range(3) == 0);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(4) == 0) ch = wsp_pkg::CHAR_DOT;
      else if (wide) ch = wsp_pkg::CHAR_A + 8'($urandom_range(25));
      else ch = wsp_pkg::CHAR_A + 8'($urandom_range(2));
      push_item(wsp_pkg::CMD_APPEND, ch);
      if (k < wsp_pkg::MAX_TOKENS) begin
        pat_ch[k] = ch;
        pat_st[k] = 1'b0;
        pat_n = k + 1;
      end
      if ($urandom_range(99) < 40) begin
        push_item(wsp_pkg::CMD_APPEND, wsp_pkg::CHAR_STAR);
        if (k < wsp_pkg::MAX_TOKENS) pat_st[k] = 1'b1;
      end
    end
    // occasional stray star (bad only after a star or at the start) or foreign character
    if ($urandom_range(99) < 8) begin
      if ($urandom_range(1) == 0) begin
        push_item(wsp_pkg::CMD_APPEND, wsp_pkg::CHAR_STAR);
      end else begin
        do ch = 8'($urandom_range(255));
        while ((ch >= wsp_pkg::CHAR_A && ch <= wsp_pkg::CHAR_Z) ||
               ch == wsp_pkg::CHAR_DOT || ch == wsp_pkg::CHAR_STAR);
        push_item(wsp_pkg::CMD_APPEND, ch);
      end
    end
  endtask

  task automatic gen_subject();
    logic [7:0] subj[64];
    int         len;
    int         reps;
    push_item(wsp_pkg::CMD_RESTART, 8'($urandom_range(255)));
    len = 0;
    for (int k = 0; k < pat_n; k++) begin
      reps = pat_st[k] ? $urandom_range(0, 3) : 1;
      for (int j = 0; j < reps; j++) begin
        subj[len] = (pat_ch[k] == wsp_pkg::CHAR_DOT) ? 8'($urandom_range(255)) : pat_ch[k];
        len++;
      end
    end
    if (len > 0 && $urandom_range(99) < 15)
      subj[$urandom_range(len - 1)] = 8'($urandom_range(255));
    if ($urandom_range(99) < 25) begin
      subj[len] = ($urandom_range(1) == 0) ? 8'($urandom_range(255))
                                            : wsp_pkg::CHAR_A + 8'($urandom_range(2));
      len++;
    end
    for (int k = 0; k < len; k++) push_item(wsp_pkg::CMD_SUBJECT, subj[k]);
  endtask

  task automatic gen_random(int target);
    while (n_fed < target) begin
      if ($urandom_range(99) < 10) begin
        repeat ($urandom_range(1, 6))
          push_item(wsp_pkg::cmd_t'($urandom_range(3)), 8'($urandom_range(255)));
      end else begin
        gen_pattern();
        repeat ($urandom_range(1, 3)) gen_subject();
      end
    end
  endtask

  task automatic gen_directed();
    push_item(wsp_pkg::CMD_RESTART, 8'h00);
    push_item(wsp_pkg::CMD_SUBJECT, wsp_pkg::CHAR_A);
    push_item(wsp_pkg::CMD_APPEND, wsp_pkg::CHAR_STAR);
    push_item(wsp_pkg::CMD_APPEND, wsp_pkg::CHAR_A);
    push_item(wsp_pkg::CMD_SUBJECT, wsp_pkg::CHAR_A);
    push_item(wsp_pkg::CMD_CLEAR, 8'hff);
    push_item(wsp_pkg::CMD_APPEND, wsp_pkg::CHAR_A);
    push_item(wsp_pkg::CMD_APPEND, wsp_pkg::CHAR_STAR);
    push_item(wsp_pkg::CMD_APPEND, wsp_pkg::CHAR_STAR);
    push_item(wsp_pkg::CMD_CLEAR, 8'h00);
    push_item(wsp_pkg::CMD_APPEND, 8'h00);
    push_item(wsp_pkg::CMD_CLEAR, 8'h00);
    push_item(wsp_pkg::CMD_APPEND, 8'hff);
    push_item(wsp_pkg::CMD_CLEAR, 8'h00);
    push_item(wsp_pkg::CMD_APPEND, wsp_pkg::CHAR_DOT);
    push_item(wsp_pkg::CMD_APPEND, wsp_pkg::CHAR_STAR);
    push_item(wsp_pkg::CMD_APPEND, wsp_pkg::CHAR_Z);
    push_item(wsp_pkg::CMD_APPEND, wsp_pkg::CHAR_STAR);
    push_item(wsp_pkg::CMD_SUBJECT, 8'hff);
    push_item(wsp_pkg::CMD_SUBJECT, wsp_pkg::CHAR_Z);
    push_item(wsp_pkg::CMD_SUBJECT, 8'h00);
    push_item(wsp_pkg::CMD_RESTART, 8'hff);
    push_item(wsp_pkg::CMD_SUBJECT, wsp_pkg::CHAR_Z);
    push_item(wsp_pkg::CMD_APPEND, wsp_pkg::CHAR_A);
    push_item(wsp_pkg::CMD_SUBJECT, wsp_pkg::CHAR_A);
  endtask

  function automatic logic drained();
    return pend_q.size() == 0 && verdict_q.size() == 0 && !in_if.valid;
  endfunction

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_if.valid   <= 1'b0;
      in_if.command <= wsp_pkg::CMD_CLEAR;
      in_if.symbol  <= 8'h00;
    end else if (!in_if.valid || in_if.ready) begin
      if (pend_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_if.valid   <= 1'b1;
        in_if.command <= pend_q[0].command;
        in_if.symbol  <= pend_q[0].symbol;
        void'(pend_q.pop_front());
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (rst) out_if.ready <= 1'b0;
    else out_if.ready <= ($urandom_range(99) >= recv_stall);
  end

  // result check first, then prediction for the transfer taken at this edge
  always @(posedge clk) begin
    verdict_t want;
    if (!rst) begin
      if (out_if.valid && out_if.ready) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected result: matched=%0b status=%0b", out_if.matched, out_if.status);
          n_err++;
        end else begin
          want = verdict_q.pop_front();
          if (out_if.matched !== want.matched) begin
            $error("matched: expected %0b, actual %0b", want.matched, out_if.matched);
            n_err++;
          end
          if (out_if.status !== want.status) begin
            $error("status: expected %0b, actual %0b", want.status, out_if.status);
            n_err++;
          end
        end
      end
      if (in_if.valid && in_if.ready)
        verdict_q.push_back(step_matcher(wsp_pkg::cmd_t'(in_if.command), in_if.symbol));
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst        = 1'b1;
    n_fed      = 0;
    send_idle  = 0;
    recv_stall = 0;
    pat_n      = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // no idling
    gen_directed();
    gen_random(PHASE_ITEMS);
    while (!drained()) @(posedge clk);

    // sender mostly idle
    @(negedge clk);
    send_idle  = 81;
    recv_stall = 0;
    gen_random(2 * PHASE_ITEMS);
    while (!drained()) @(posedge clk);

    // receiver mostly stalled
    @(negedge clk);
    send_idle  = 0;
    recv_stall = 81;
    gen_random(3 * PHASE_ITEMS);
    while (!drained()) @(posedge clk);

    // both sides idle now and then
    @(negedge clk);
    send_idle  = 32;
    recv_stall = 32;
    gen_random(4 * PHASE_ITEMS);
    while (!drained()) @(posedge clk);

    repeat (8) @(posedge clk);
    if (n_err == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
